// File: hdl/hbe_pkg.sv
package hbe_pkg;

	localparam int N_BASIS   = 8;
	localparam int N_COEFFS  = 8;
	localparam int N_CELLS   = N_COEFFS - 1;
	localparam int BASIS_W   = 3;
	localparam int POS_W     = 3;
	localparam int CNT_W     = 4;
	localparam int X_W       = 18;
	localparam int D_W       = 32;
	localparam int PROD_W    = D_W + X_W;
	localparam int SUM_W     = PROD_W + 1;
	localparam int FRAC_W    = 16;
	localparam int CFG_IDX_W = 2;

	// Request types.
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_EVAL = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_BASIS_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COEFF_COUNT = 2'd1;

	// One basis evaluation travelling down the chain.
	typedef struct packed {
		logic                     valid;
		logic [BASIS_W-1:0]       basis;
		logic                     last;
		logic                     sat;
		logic signed [D_W-1:0]    acc;
	} tok_t;

	// Coefficient write broadcast to every cell.
	typedef struct packed {
		logic                     wr_en;
		logic [BASIS_W-1:0]       basis;
		logic [POS_W-1:0]         pos;
		logic [D_W-1:0]           value;
	} load_t;

endpackage

// File: hdl/hbe_if.sv
interface hbe_req_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 req_type;
	logic [hbe_pkg::BASIS_W-1:0]          basis_sel;
	logic [hbe_pkg::POS_W-1:0]            coeff_sel;
	logic signed [hbe_pkg::D_W-1:0]       coeff_value;
	logic signed [hbe_pkg::X_W-1:0]       x_value;

	modport source (output valid, req_type, basis_sel, coeff_sel, coeff_value, x_value,
		input ready);
	modport sink (input valid, req_type, basis_sel, coeff_sel, coeff_value, x_value,
		output ready);
endinterface

interface hbe_res_if;
	logic                                 valid;
	logic                                 ready;
	logic [hbe_pkg::BASIS_W-1:0]          basis_id;
	logic signed [hbe_pkg::D_W-1:0]       poly_value;
	logic                                 last_value;
	logic                                 sat_flag;

	modport source (output valid, basis_id, poly_value, last_value, sat_flag, input ready);
	modport sink (input valid, basis_id, poly_value, last_value, sat_flag, output ready);
endinterface

interface hbe_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [hbe_pkg::CFG_IDX_W-1:0]        index;
	logic [hbe_pkg::CNT_W-1:0]            data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/hbe_issue.sv
module hbe_issue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic                        start,
	input  logic [hbe_pkg::CNT_W-1:0]   basis_num,
	input  hbe_pkg::load_t              load,
	output hbe_pkg::tok_t               tok_out
);

	// Leading coefficients, one per basis polynomial.
	logic [hbe_pkg::D_W-1:0]       lead_mem [hbe_pkg::N_BASIS];

	logic                          issuing_q;
	logic [hbe_pkg::BASIS_W-1:0]   idx_q;
	logic                          v_s1;
	logic [hbe_pkg::BASIS_W-1:0]   basis_s1;
	logic                          last_s1;
	logic [hbe_pkg::D_W-1:0]       acc_s1;
	logic                          is_last;

	assign is_last = ({1'b0, idx_q} == (basis_num - 4'd1));

	always_ff @(posedge clk) begin
		if (load.wr_en && load.pos == '0) begin
			lead_mem[load.basis] <= load.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issuing_q <= 1'b0;
			idx_q     <= '0;
			v_s1      <= 1'b0;
		end else begin
			if (start) begin
				issuing_q <= 1'b1;
				idx_q     <= '0;
			end else if (adv && issuing_q) begin
				idx_q <= idx_q + 3'd1;
				if (is_last) begin
					issuing_q <= 1'b0;
				end
			end
			if (adv) begin
				v_s1 <= issuing_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && issuing_q) begin
			acc_s1   <= lead_mem[idx_q];
			basis_s1 <= idx_q;
			last_s1  <= is_last;
		end
	end

	assign tok_out.valid = v_s1;
	assign tok_out.basis = basis_s1;
	assign tok_out.last  = last_s1;
	assign tok_out.sat   = 1'b0;
	assign tok_out.acc   = $signed(acc_s1);

endmodule

// File: hdl/hbe_cell.sv
module hbe_cell (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               adv,
	input  logic [hbe_pkg::POS_W-1:0]          cell_pos,
	input  logic [hbe_pkg::CNT_W-1:0]          coeff_num,
	input  logic signed [hbe_pkg::X_W-1:0]     x,
	input  hbe_pkg::load_t                     load,
	input  hbe_pkg::tok_t                      tok_in,
	output hbe_pkg::tok_t                      tok_out
);

	// This cell's coefficient column: position cell_pos of every basis polynomial.
	logic [hbe_pkg::D_W-1:0]             coef_mem [hbe_pkg::N_BASIS];

	logic                                v_s1;
	logic [hbe_pkg::BASIS_W-1:0]         basis_s1;
	logic                                last_s1;
	logic                                sat_s1;
	logic signed [hbe_pkg::D_W-1:0]      acc_s1;
	logic [hbe_pkg::D_W-1:0]             coef_s1;
	logic signed [hbe_pkg::PROD_W-1:0]   prod_s1;

	logic                                v_s2;
	logic [hbe_pkg::BASIS_W-1:0]         basis_s2;
	logic                                last_s2;
	logic                                sat_s2;
	logic signed [hbe_pkg::D_W-1:0]      acc_s2;

	logic                                active;
	logic [hbe_pkg::SUM_W-1:0]           sum;
	logic [hbe_pkg::SUM_W-hbe_pkg::FRAC_W-1:0] rnd;
	logic                                ovf;
	logic signed [hbe_pkg::D_W-1:0]      step_val;

	assign active = ({1'b0, cell_pos} < coeff_num);

	always_ff @(posedge clk) begin
		if (load.wr_en && load.pos == cell_pos) begin
			coef_mem[load.basis] <= load.value;
		end
	end

	// Stage 1: product and coefficient read.
	always_ff @(posedge clk) begin
		if (adv) begin
			basis_s1 <= tok_in.basis;
			last_s1  <= tok_in.last;
			sat_s1   <= tok_in.sat;
			acc_s1   <= tok_in.acc;
			coef_s1  <= coef_mem[tok_in.basis];
			prod_s1  <= $signed(tok_in.acc) * x;
		end
	end

	// Stage 2: add coefficient plus one half, floor to 16 fraction bits, saturate (active cells only).
	always_comb begin
		sum = {prod_s1[hbe_pkg::PROD_W-1], prod_s1}
			+ {{3{coef_s1[hbe_pkg::D_W-1]}}, coef_s1, 16'h8000};
		rnd = sum[hbe_pkg::SUM_W-1:hbe_pkg::FRAC_W];
		ovf = !((rnd[hbe_pkg::SUM_W-hbe_pkg::FRAC_W-1:hbe_pkg::D_W-1] == '0)
			|| (rnd[hbe_pkg::SUM_W-hbe_pkg::FRAC_W-1:hbe_pkg::D_W-1] == '1));
		if (!ovf) begin
			step_val = $signed(rnd[hbe_pkg::D_W-1:0]);
		end else if (rnd[hbe_pkg::SUM_W-hbe_pkg::FRAC_W-1]) begin
			step_val = $signed({1'b1, {(hbe_pkg::D_W-1){1'b0}}});
		end else begin
			step_val = $signed({1'b0, {(hbe_pkg::D_W-1){1'b1}}});
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			basis_s2 <= basis_s1;
			last_s2  <= last_s1;
			if (active) begin
				acc_s2 <= step_val;
				sat_s2 <= sat_s1 | ovf;
			end else begin
				acc_s2 <= acc_s1;
				sat_s2 <= sat_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= tok_in.valid;
			v_s2 <= v_s1;
		end
	end

	assign tok_out.valid = v_s2;
	assign tok_out.basis = basis_s2;
	assign tok_out.last  = last_s2;
	assign tok_out.sat   = sat_s2;
	assign tok_out.acc   = acc_s2;

endmodule

// File: hdl/horner_basis_evaluator_top.sv
// Channel  Dir  Handshake     Carries
// req      in   valid/ready   req_type, basis_sel, coeff_sel, coeff_value, x_value
// res      out  valid/ready   basis_id, poly_value, last_value, sat_flag
// cfg      in   valid/ready   index (0 basis_count, 1 coeff_count), data
//
// A load request writes its coefficient when accepted, and loads may follow each other directly.
// Any request after an evaluate waits until ready returns.
// An evaluate request issues one basis token per cycle from the
// leading-coefficient memory while res does not stall, nb tokens in all, where
// nb is the clamped basis count; each token then passes through the seven Horner
// cells and the output register. Ready returns when the last result is loaded.
// Reset clears all control state and sets both counts to eight; coefficient
// storage keeps no reset value. A stall on res freezes the whole cell chain.
module horner_basis_evaluator_top (
	input  logic          clk,
	input  logic          arst_n,
	hbe_req_if.sink       req,
	hbe_res_if.source     res,
	hbe_cfg_if.sink       cfg
);

	logic [hbe_pkg::CNT_W-1:0]          basis_count_q;
	logic [hbe_pkg::CNT_W-1:0]          coeff_count_q;
	logic [hbe_pkg::CNT_W-1:0]          basis_num;
	logic [hbe_pkg::CNT_W-1:0]          coeff_num;

	logic                               busy_q;
	logic signed [hbe_pkg::X_W-1:0]     x_q;
	logic                               adv;
	logic                               req_acc;
	logic                               start;
	hbe_pkg::load_t                     load;
	hbe_pkg::tok_t                      chain [hbe_pkg::N_CELLS+1];
	hbe_pkg::tok_t                      tail;

	logic                               out_valid_q;
	logic [hbe_pkg::BASIS_W-1:0]        out_basis_q;
	logic signed [hbe_pkg::D_W-1:0]     out_value_q;
	logic                               out_last_q;
	logic                               out_sat_q;

	// Configuration registers. The counts are clamped to one through eight
	// where they are used, so any written value is harmless.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			basis_count_q <= 4'd8;
			coeff_count_q <= 4'd8;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				hbe_pkg::CFG_BASIS_COUNT: basis_count_q <= cfg.data;
				hbe_pkg::CFG_COEFF_COUNT: coeff_count_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (basis_count_q == '0) begin
			basis_num = 4'd1;
		end else if (basis_count_q > 4'(hbe_pkg::N_BASIS)) begin
			basis_num = 4'(hbe_pkg::N_BASIS);
		end else begin
			basis_num = basis_count_q;
		end
		if (coeff_count_q == '0) begin
			coeff_num = 4'd1;
		end else if (coeff_count_q > 4'(hbe_pkg::N_COEFFS)) begin
			coeff_num = 4'(hbe_pkg::N_COEFFS);
		end else begin
			coeff_num = coeff_count_q;
		end
	end

	// Requests are taken whenever no evaluation is in flight, so a load can
	// never change a coefficient that an earlier evaluation still needs.
	assign req.ready = !busy_q;
	assign req_acc   = req.valid && !busy_q;
	assign start     = req_acc && (req.req_type == hbe_pkg::REQ_EVAL);

	assign load.wr_en = req_acc && (req.req_type == hbe_pkg::REQ_LOAD);
	assign load.basis = req.basis_sel;
	assign load.pos   = req.coeff_sel;
	assign load.value = req.coeff_value;

	// The chain moves only when the output register can take its tail.
	assign adv  = !out_valid_q || res.ready;
	assign tail = chain[hbe_pkg::N_CELLS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (adv && tail.valid && tail.last) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= req.x_value;
		end
	end

	hbe_issue u_issue (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.start     (start),
		.basis_num (basis_num),
		.load      (load),
		.tok_out   (chain[0])
	);

	// Cell k applies coefficient position k + 1; cells past the active count
	// pass the running value through unchanged.
	for (genvar k = 0; k < hbe_pkg::N_CELLS; k++) begin : g_cell
		hbe_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.cell_pos  (hbe_pkg::POS_W'(k + 1)),
			.coeff_num (coeff_num),
			.x         (x_q),
			.load      (load),
			.tok_in    (chain[k]),
			.tok_out   (chain[k+1])
		);
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= tail.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_basis_q <= tail.basis;
			out_value_q <= tail.acc;
			out_last_q  <= tail.last;
			out_sat_q   <= tail.sat;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.basis_id   = out_basis_q;
	assign res.poly_value = out_value_q;
	assign res.last_value = out_last_q;
	assign res.sat_flag   = out_sat_q;

	// A token can only be in the chain while an evaluation is open.
	a_tail_in_eval: assert property (@(posedge clk) disable iff (!arst_n)
		tail.valid |-> busy_q)
		else $error("result token in chain with no evaluation open");

	a_issue_in_eval: assert property (@(posedge clk) disable iff (!arst_n)
		chain[0].valid |-> busy_q)
		else $error("issued token with no evaluation open");

	// The marked result is always the last basis in use.
	a_last_id: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.last_value) |-> ({1'b0, res.basis_id} == basis_num - 4'd1))
		else $error("last result carries wrong basis number");

	a_not_last_id: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.last_value) |-> ({1'b0, res.basis_id} < basis_num - 4'd1))
		else $error("unmarked result past the last basis");

	// Starting an evaluation leaves the block busy in the next cycle.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q)
		else $error("evaluation accepted but block not busy");

endmodule
